// ===== sv/cssp_pkg.sv =====
// Shared types and constants of the serial-programmed clock synthesiser core.
// No dependencies; the front end, queue, back end, top level and checker import it.
package cssp_pkg;

  localparam int TableEntries = 16;
  localparam int QueueDepth   = 4;
  localparam int FrameBits    = 20;
  localparam int SelWidth     = 4;
  localparam int FreqWidth    = 28;
  localparam int NFieldWidth  = 8;
  localparam int NWidth       = 10;
  localparam int ScaleWidth   = 35;
  localparam int ProdWidth    = NWidth + ScaleWidth;
  localparam int FracBits     = 16;
  localparam int MaxDivLog2   = 3;

  localparam logic [NWidth-1:0]     NOffset      = 10'd257;
  localparam logic [ScaleWidth-1:0] FreqScaleQ16 = 35'd20399051357;
  localparam logic [FreqWidth-1:0]  FreqMax      = 28'd159367888;

  typedef struct packed {
    logic [SelWidth-1:0]    sel;
    logic                   write;
    logic [3:0]             idx;
    logic [NFieldWidth-1:0] n_field;
    logic [1:0]             div_sel;
  } cssp_op_t;

endpackage

// ===== sv/cssp_in_if.sv =====
// Input channel of the synthesiser core: strobe and select lines of one access.
// Depends on nothing.
interface cssp_in_if;
  logic       valid;
  logic       ready;
  logic       strobe_req;
  logic [3:0] select_bits;

  modport source(output valid, strobe_req, select_bits, input ready);
  modport sink(input valid, strobe_req, select_bits, output ready);
endinterface

// ===== sv/cssp_out_if.sv =====
// Result channel of the synthesiser core: selected frequency and write flag.
// Depends on nothing.
interface cssp_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] clock_hz;
  logic        entry_written;

  modport source(output valid, clock_hz, entry_written, input ready);
  modport sink(input valid, clock_hz, entry_written, output ready);
endinterface

// ===== sv/cssp_front.sv =====
// Front end: accepts accesses, runs the serial frame decoder and classifies
// each item as read-only or entry write. Depends on cssp_pkg and cssp_in_if.
module cssp_front (
  input  logic              clk,
  input  logic              rst,
  cssp_in_if.sink           access,
  output logic              push_valid,
  output cssp_pkg::cssp_op_t push_op,
  input  logic              push_ready
);
  import cssp_pkg::*;

  logic                 frame_active, frame_active_next;
  logic [4:0]           bit_count, bit_count_next;
  logic [FrameBits-1:0] shift_word, shift_word_next;
  logic                 prev_data_clock, prev_data_clock_next;
  logic                 write_next;
  logic                 data_clock, data_bit, accept;

  assign access.ready = push_ready;
  assign accept       = access.valid && push_ready;
  assign data_clock   = access.select_bits[3];
  assign data_bit     = access.select_bits[2];

  always_comb begin
    frame_active_next    = frame_active;
    bit_count_next       = bit_count;
    shift_word_next      = shift_word;
    prev_data_clock_next = prev_data_clock;
    write_next           = 1'b0;
    if (access.strobe_req) begin
      if (data_clock && !prev_data_clock) begin
        if (!frame_active) begin
          frame_active_next = data_bit;
          bit_count_next    = 5'd0;
        end else begin
          shift_word_next = {data_bit, shift_word[FrameBits-1:1]};
          bit_count_next  = bit_count + 5'd1;
          if (bit_count_next >= 5'(FrameBits)) begin
            frame_active_next = 1'b0;
            write_next        = 1'b1;
          end
        end
      end
      prev_data_clock_next = data_clock;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active    <= 1'b0;
      bit_count       <= 5'd0;
      shift_word      <= '0;
      prev_data_clock <= 1'b0;
    end else if (accept) begin
      frame_active    <= frame_active_next;
      bit_count       <= bit_count_next;
      shift_word      <= shift_word_next;
      prev_data_clock <= prev_data_clock_next;
    end
  end

  assign push_valid      = access.valid;
  assign push_op.sel     = access.select_bits;
  assign push_op.write   = write_next;
  assign push_op.idx     = shift_word_next[5:2];
  assign push_op.n_field = shift_word_next[14:7];
  assign push_op.div_sel = shift_word_next[17:16];
endmodule

// ===== sv/cssp_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on cssp_pkg.
module cssp_queue #(
  parameter int DEPTH = cssp_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  input  cssp_pkg::cssp_op_t push_op,
  output logic               push_ready,
  output logic               pop_valid,
  output cssp_pkg::cssp_op_t pop_op,
  input  logic               pop_ready
);
  import cssp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cssp_op_t        slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign push_ready = count != CntW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end
endmodule

// ===== sv/cssp_back.sv =====
// Back end: multiplies N by the scaled reference, applies the post divider,
// updates the frequency table and returns the selected entry.
// Depends on cssp_pkg and cssp_out_if.
module cssp_back #(
  parameter int TABLE_ENTRIES = cssp_pkg::TableEntries
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  input  cssp_pkg::cssp_op_t op,
  output logic               op_ready,
  cssp_out_if.source         result
);
  import cssp_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);

  typedef struct packed {
    logic [SelWidth-1:0]  sel;
    logic                 write;
    logic [3:0]           idx;
    logic [ProdWidth-1:0] product;
    logic [1:0]           div_sel;
  } cssp_mul_t;

  logic [FreqWidth-1:0] freq_table [TABLE_ENTRIES];
  cssp_mul_t            mul;
  logic                 mul_valid;
  logic                 out_valid;
  logic [FreqWidth-1:0] out_hz;
  logic                 out_written;
  logic                 out_load;
  logic [NWidth-1:0]    n_value;
  logic [ProdWidth-1:0] product_next;
  logic [ProdWidth-1:0] scaled;
  logic [FreqWidth-1:0] freq;
  logic [FreqWidth-1:0] read_hz;
  logic [IdxW-1:0]      wr_idx, rd_idx;

  assign out_load = mul_valid && (!out_valid || result.ready);
  assign op_ready = !mul_valid || out_load;

  assign n_value      = NWidth'(op.n_field) + NOffset;
  assign product_next = ProdWidth'(n_value) * ProdWidth'(FreqScaleQ16);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (op_ready) begin
      mul_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      mul.sel     <= op.sel;
      mul.write   <= op.write;
      mul.idx     <= op.idx;
      mul.product <= product_next;
      mul.div_sel <= op.div_sel;
    end
  end

  assign scaled  = mul.product >> (FracBits + MaxDivLog2 - int'(mul.div_sel));
  assign freq    = scaled[FreqWidth-1:0];
  assign wr_idx  = mul.idx[IdxW-1:0];
  assign rd_idx  = mul.sel[IdxW-1:0];
  assign read_hz = (mul.write && wr_idx == rd_idx) ? freq : freq_table[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        freq_table[i] <= '0;
      end
    end else if (out_load && mul.write) begin
      freq_table[wr_idx] <= freq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hz      <= read_hz;
      out_written <= mul.write;
    end
  end

  assign result.valid         = out_valid;
  assign result.clock_hz      = out_hz;
  assign result.entry_written = out_written;
endmodule

// ===== sv/clock_synth_serial_program_core.sv =====
// Serial-programmed clock synthesiser core: one access item in, one result out.
// Accepts one item per clock when the result side keeps up; a result is offered
// after its access passes the queue slot, the multiplier stage and the output
// register (the frame decoder is combinational ahead of the queue). Rate is set
// by the frame decoder in the front end, which advances once per
// item. The 16-entry frequency table is held in flip-flops cleared by reset, so
// no clearing pass is needed and items are taken from the first cycle after
// reset. Depends on cssp_pkg, cssp_in_if, cssp_out_if, cssp_front, cssp_queue
// and cssp_back.
module clock_synth_serial_program_core #(
  parameter int TABLE_ENTRIES = cssp_pkg::TableEntries,
  parameter int QUEUE_DEPTH   = cssp_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  cssp_in_if.sink    access,
  cssp_out_if.source result
);
  import cssp_pkg::*;

  logic     push_valid, push_ready;
  cssp_op_t push_op;
  logic     pop_valid, pop_ready;
  cssp_op_t pop_op;

  cssp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .access     (access),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready)
  );

  cssp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  cssp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (pop_valid),
    .op       (pop_op),
    .op_ready (pop_ready),
    .result   (result)
  );
endmodule

// ===== sv/cssp_checker.sv =====
// Port-level checks of the synthesiser core, bound to the top level.
// Depends on cssp_pkg and clock_synth_serial_program_core.
module cssp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [27:0] clock_hz,
  input logic        entry_written
);
  import cssp_pkg::*;

  localparam int Capacity = QueueDepth + 2;

  logic [3:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result with no item outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(Capacity))
    else $error("more items outstanding than the pipeline holds");

  a_backlog: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pending >= 4'(QueueDepth))
    else $error("input stalled without a full queue");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> clock_hz <= FreqMax)
    else $error("frequency beyond the synthesiser range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clock_hz) && $stable(entry_written))
    else $error("stalled result changed");
endmodule

bind clock_synth_serial_program_core cssp_checker u_cssp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (access.valid),
  .in_ready      (access.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .clock_hz      (result.clock_hz),
  .entry_written (result.entry_written)
);
